// ===== hdl/uf_pkg.sv =====
package uf_pkg;

    localparam int IDX_W    = 7;
    localparam int ELEMENTS = 1 << IDX_W;
    localparam int SIZE_W   = 7;
    localparam int STEP_W   = IDX_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_MAX  = {SIZE_W{1'b1}};
    localparam logic [STEP_W-1:0] WALK_LAST = STEP_W'(ELEMENTS - 1);

    // request modes
    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_UNION  = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_ACCEPT   = 4'd1;
    localparam logic [3:0] OP_START    = 4'd2;
    localparam logic [3:0] OP_WALK     = 4'd3;
    localparam logic [3:0] OP_CHECK    = 4'd4;
    localparam logic [3:0] OP_COMPRESS = 4'd5;
    localparam logic [3:0] OP_SIZE_A   = 4'd6;
    localparam logic [3:0] OP_SIZE_B   = 4'd7;
    localparam logic [3:0] OP_FINISH   = 4'd8;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
    } uf_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  root_a;
        logic [IDX_W-1:0]  root_b;
        logic              same_set;
        logic              merged;
        logic [SIZE_W-1:0] root_size;
        logic              error;
    } uf_rsp_t;

    typedef struct packed {
        logic [3:0] op;
        logic       second;
    } uf_cmd_t;

    typedef struct packed {
        logic quick;
        logic walk_end;
        logic cmp_end;
    } uf_stat_t;

endpackage

// ===== hdl/union_find_engine.sv =====
// channel   ports                         word         accepted when
// command   start, busy, request          uf_req_t     start & !busy at clk rise
// result    done, result                  uf_rsp_t     done high (one cycle, no stall)
// config    cfg_we, cfg_data              7 bits       cfg_we high at clk rise
//
// find/union: both indices walk their links to the root and then compress them;
// every link costs one walk read plus a read and a write-back on the single-port
// parent table
// reinit, unused mode and bad index: done the cycle after accept, busy stays low
// reset (rst_n low, async) marks every table entry as its reset value at once,
// no clearing pass; the result side has no stall
module union_find_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  uf_pkg::uf_req_t request,
    output logic            done,
    output uf_pkg::uf_rsp_t result,
    input  logic            cfg_we,
    input  logic [6:0]      cfg_data
);

    uf_pkg::uf_cmd_t  cmd;
    uf_pkg::uf_stat_t stat;

    uf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    uf_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result),
        .done     (done)
    );

endmodule

// ===== hdl/uf_ctrl.sv =====
module uf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  uf_pkg::uf_stat_t stat,
    output uf_pkg::uf_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_COMP   = 3'd4;
    localparam logic [2:0] S_SIZE_A = 3'd5;
    localparam logic [2:0] S_SIZE_B = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       second_reg;
    logic       second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd.op      = uf_pkg::OP_NONE;
        cmd.second  = second_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op      = uf_pkg::OP_ACCEPT;
                    second_next = 1'b0;
                    if (!stat.quick)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.op     = uf_pkg::OP_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.op = uf_pkg::OP_WALK;
                if (stat.walk_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.op = uf_pkg::OP_CHECK;
                if (!stat.cmp_end)
                begin
                    state_next = S_COMP;
                end
                else if (second_reg)
                begin
                    state_next = S_SIZE_A;
                end
                else
                begin
                    second_next = 1'b1;
                    state_next  = S_START;
                end
            end
            S_COMP:
            begin
                cmd.op     = uf_pkg::OP_COMPRESS;
                state_next = S_CHECK;
            end
            S_SIZE_A:
            begin
                cmd.op     = uf_pkg::OP_SIZE_A;
                state_next = S_SIZE_B;
            end
            S_SIZE_B:
            begin
                cmd.op     = uf_pkg::OP_SIZE_B;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op     = uf_pkg::OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/uf_dpath.sv =====
module uf_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  uf_pkg::uf_req_t   request,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_data,
    input  uf_pkg::uf_cmd_t   cmd,
    output uf_pkg::uf_stat_t  stat,
    output uf_pkg::uf_rsp_t   result,
    output logic              done
);

    localparam int IW = uf_pkg::IDX_W;
    localparam int SW = uf_pkg::SIZE_W;
    localparam int TW = uf_pkg::STEP_W;
    localparam int EL = uf_pkg::ELEMENTS;

    // table memories, entries without a valid bit read as their reset value
    logic [IW-1:0] parent_mem [EL];
    logic [SW-1:0] size_mem   [EL];
    logic [EL-1:0] pvalid_reg;
    logic [EL-1:0] svalid_reg;

    logic [IW-1:0] pq_reg;
    logic          pv_q_reg;
    logic [IW-1:0] paddr_q_reg;
    logic [SW-1:0] sq_reg;
    logic          sv_q_reg;

    logic [IW-1:0] p_addr;
    logic          p_we;
    logic [IW-1:0] p_wdata;
    logic [IW-1:0] s_addr;
    logic          s_we;
    logic [SW-1:0] s_wdata;

    logic [IW-1:0] count_reg;
    logic          done_reg;
    logic          done_next;
    uf_pkg::uf_req_t req_reg;
    uf_pkg::uf_rsp_t rsp_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] root_reg;
    logic [IW-1:0] ra_reg;
    logic [IW-1:0] rb_reg;
    logic [SW-1:0] sa_reg;
    logic [TW-1:0] step_reg;

    logic [IW-1:0] p_eff;
    logic [SW-1:0] s_eff;
    logic [IW-1:0] node_sel;
    logic          bad_a;
    logic          bad_b;
    logic          quick;
    logic          reinit;
    logic          walk_end;
    logic          cmp_end;
    logic          merge;
    logic [IW-1:0] big;
    logic [IW-1:0] small_root;
    logic [SW:0]   sum;
    logic [SW-1:0] sum_sat;

    assign p_eff    = pv_q_reg ? pq_reg : paddr_q_reg;
    assign s_eff    = sv_q_reg ? sq_reg : SW'(1);
    assign node_sel = cmd.second ? req_reg.second_index : req_reg.first_index;

    assign bad_a  = (request.first_index == '0) || (request.first_index > count_reg);
    assign bad_b  = (request.second_index == '0) || (request.second_index > count_reg);
    assign quick  = request.mode[1] || bad_a || bad_b;
    assign reinit = (cmd.op == uf_pkg::OP_ACCEPT) && (request.mode == uf_pkg::MODE_REINIT);

    assign walk_end = (p_eff == cur_reg) || (step_reg == uf_pkg::WALK_LAST);
    assign cmp_end  = (cur_reg == root_reg) || step_reg[TW-1];

    assign stat.quick    = quick;
    assign stat.walk_end = walk_end;
    assign stat.cmp_end  = cmp_end;

    // union by size, first root wins a tie
    assign merge      = (req_reg.mode == uf_pkg::MODE_UNION) && (ra_reg != rb_reg);
    assign big        = (sa_reg < s_eff) ? rb_reg : ra_reg;
    assign small_root = (sa_reg < s_eff) ? ra_reg : rb_reg;
    assign sum        = {1'b0, sa_reg} + {1'b0, s_eff};
    assign sum_sat    = (sum > {1'b0, uf_pkg::SIZE_MAX}) ? uf_pkg::SIZE_MAX : sum[SW-1:0];

    always_comb
    begin
        p_addr  = cur_reg;
        p_we    = 1'b0;
        p_wdata = root_reg;
        s_addr  = ra_reg;
        s_we    = 1'b0;
        s_wdata = sum_sat;
        unique case (cmd.op)
            uf_pkg::OP_START:    p_addr = node_sel;
            uf_pkg::OP_WALK:     p_addr = p_eff;
            uf_pkg::OP_COMPRESS: p_we   = 1'b1;
            uf_pkg::OP_SIZE_B:   s_addr = rb_reg;
            uf_pkg::OP_FINISH:
            begin
                p_addr  = small_root;
                p_we    = merge;
                p_wdata = big;
                s_addr  = big;
                s_we    = merge;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_addr] <= p_wdata;
        end
        else
        begin
            pq_reg <= parent_mem[p_addr];
        end
        pv_q_reg    <= pvalid_reg[p_addr];
        paddr_q_reg <= p_addr;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            size_mem[s_addr] <= s_wdata;
        end
        else
        begin
            sq_reg <= size_mem[s_addr];
        end
        sv_q_reg <= svalid_reg[s_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            svalid_reg <= '0;
        end
        else
        begin
            if (p_we)
            begin
                pvalid_reg[p_addr] <= 1'b1;
            end
            if (s_we)
            begin
                svalid_reg[s_addr] <= 1'b1;
            end
            if (reinit)
            begin
                for (int i = 1; i < EL; i++)
                begin
                    if (IW'(i) <= count_reg)
                    begin
                        pvalid_reg[i] <= 1'b0;
                        svalid_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

    assign done_next = ((cmd.op == uf_pkg::OP_ACCEPT) && quick) ||
                       (cmd.op == uf_pkg::OP_FINISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= IW'(EL - 1);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            uf_pkg::OP_ACCEPT:
            begin
                req_reg           <= request;
                rsp_reg.root_a    <= '0;
                rsp_reg.root_b    <= '0;
                rsp_reg.same_set  <= 1'b0;
                rsp_reg.merged    <= 1'b0;
                rsp_reg.root_size <= '0;
                rsp_reg.error     <= !request.mode[1] && (bad_a || bad_b);
            end
            uf_pkg::OP_START:
            begin
                cur_reg  <= node_sel;
                step_reg <= '0;
            end
            uf_pkg::OP_WALK:
            begin
                root_reg <= (p_eff == cur_reg) ? cur_reg : p_eff;
                if (walk_end)
                begin
                    cur_reg  <= node_sel;
                    step_reg <= '0;
                end
                else
                begin
                    cur_reg  <= p_eff;
                    step_reg <= step_reg + TW'(1);
                end
            end
            uf_pkg::OP_CHECK:
            begin
                if (cmp_end)
                begin
                    if (cmd.second)
                    begin
                        rb_reg <= root_reg;
                    end
                    else
                    begin
                        ra_reg <= root_reg;
                    end
                end
            end
            uf_pkg::OP_COMPRESS:
            begin
                cur_reg  <= p_eff;
                step_reg <= step_reg + TW'(1);
            end
            uf_pkg::OP_SIZE_B:
            begin
                sa_reg <= s_eff;
            end
            uf_pkg::OP_FINISH:
            begin
                rsp_reg.error <= 1'b0;
                if (merge)
                begin
                    rsp_reg.root_a    <= big;
                    rsp_reg.root_b    <= big;
                    rsp_reg.same_set  <= 1'b1;
                    rsp_reg.merged    <= 1'b1;
                    rsp_reg.root_size <= sum_sat;
                end
                else
                begin
                    rsp_reg.root_a    <= ra_reg;
                    rsp_reg.root_b    <= rb_reg;
                    rsp_reg.same_set  <= (ra_reg == rb_reg);
                    rsp_reg.merged    <= 1'b0;
                    rsp_reg.root_size <= sa_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule
